// ----- sv/assert_macros.svh -----
// Assertion macros used by the top-level RTL file of the console buss output stage.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cbsfc_pkg.sv -----
// Package of the console buss output stage: widths, register indexes, fixed-point
// constants and the rounding, saturation and reciprocal helpers. No dependencies.
`default_nettype none

package cbsfc_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int GAIN_W      = 26;
    localparam int COEF_W      = 32;
    localparam int STATE_W     = 40;
    localparam int MUL_W       = 34;
    localparam int PROD_W      = 68;
    localparam int CFG_INDEX_W = 3;
    localparam int RAM_DEPTH   = 3;
    localparam int RAM_ADDR_W  = 2;
    localparam int DIV_STEPS   = 6;

    typedef logic signed [MUL_W-1:0]    mul_op_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [STATE_W-1:0]  fstate_t;
    typedef logic [CFG_INDEX_W-1:0]     cfg_index_t;
    typedef logic [RAM_ADDR_W-1:0]      ram_addr_t;

    localparam cfg_index_t CFG_FILTER_ENABLE = 3'd0;
    localparam cfg_index_t CFG_COEF_A0       = 3'd1;
    localparam cfg_index_t CFG_COEF_B1       = 3'd2;
    localparam cfg_index_t CFG_COEF_B2       = 3'd3;
    localparam cfg_index_t CFG_DELAY_SPACING = 3'd4;

    localparam ram_addr_t ADDR_S1   = 2'd0;
    localparam ram_addr_t ADDR_S2   = 2'd1;
    localparam ram_addr_t ADDR_HELD = 2'd2;

    localparam sample_t HALF_PI_Q24 = 32'sd26353589;
    localparam sample_t FOUR_Q24    = 32'sd67108864;
    localparam sample_t CLIP_THRESH = 32'sd16022117;
    localparam sample_t NEG_THRESH  = -32'sd16022117;
    localparam sample_t CLIP_BASE   = 32'sd11841708;
    localparam sample_t NEG_BASE    = -32'sd11841708;
    localparam sample_t CLIP_MUL    = 32'sd4377424;
    localparam sample_t REL_BASE    = 32'sd4180407;
    localparam sample_t NEG_REL     = -32'sd4180407;
    localparam sample_t REL_MUL     = 32'sd12399790;
    localparam sample_t ONE_Q30     = 32'sd1073741824;

    // Exact reciprocals for the series divisors 156, 110, 72, 42, 20 and 6 on
    // 32-bit dividends: ceil(2^(32+l)/d) with l = ceil(log2(d)).
    localparam logic [63:0] DIV_MUL_0 = ((64'd1 << 40) + 64'd155) / 64'd156;
    localparam logic [63:0] DIV_MUL_1 = ((64'd1 << 39) + 64'd109) / 64'd110;
    localparam logic [63:0] DIV_MUL_2 = ((64'd1 << 39) + 64'd71) / 64'd72;
    localparam logic [63:0] DIV_MUL_3 = ((64'd1 << 38) + 64'd41) / 64'd42;
    localparam logic [63:0] DIV_MUL_4 = ((64'd1 << 37) + 64'd19) / 64'd20;
    localparam logic [63:0] DIV_MUL_5 = ((64'd1 << 35) + 64'd5) / 64'd6;

    function automatic logic [32:0] div_mul(input logic [2:0] k);
        logic [32:0] m;
        case (k)
            3'd0: m = DIV_MUL_0[32:0];
            3'd1: m = DIV_MUL_1[32:0];
            3'd2: m = DIV_MUL_2[32:0];
            3'd3: m = DIV_MUL_3[32:0];
            3'd4: m = DIV_MUL_4[32:0];
            3'd5: m = DIV_MUL_5[32:0];
            default: m = DIV_MUL_0[32:0];
        endcase
        return m;
    endfunction

    function automatic logic [29:0] div_quot(input prod_t p, input logic [2:0] k);
        prod_t s;
        case (k)
            3'd0: s = p >>> 40;
            3'd1: s = p >>> 39;
            3'd2: s = p >>> 39;
            3'd3: s = p >>> 38;
            3'd4: s = p >>> 37;
            3'd5: s = p >>> 35;
            default: s = p >>> 40;
        endcase
        return s[29:0];
    endfunction

    // Round to nearest, ties toward plus infinity.
    function automatic prod_t rnd_shift(input prod_t v, input int unsigned sh);
        prod_t half;
        half = prod_t'(1) <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

    function automatic sample_t clamp_sym(input prod_t v, input sample_t lim);
        sample_t r;
        if (v > prod_t'(lim)) begin
            r = lim;
        end else if (v < -prod_t'(lim)) begin
            r = -lim;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    function automatic sample_t sat32(input prod_t v);
        sample_t r;
        if (v > prod_t'(32'sh7FFF_FFFF)) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -prod_t'(33'sh0_8000_0000)) begin
            r = -32'sh8000_0000;
        end else begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

    function automatic fstate_t sat40(input prod_t v);
        fstate_t r;
        if (v > prod_t'(41'sh0_7F_FFFF_FFFF)) begin
            r = 40'sh7F_FFFF_FFFF;
        end else if (v < -prod_t'(42'sh0_80_0000_0000)) begin
            r = -40'sh80_0000_0000;
        end else begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/cbsfc_ram.sv -----
// Generic synchronous RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module cbsfc_ram #(
    parameter int WIDTH  = 40,
    parameter int DEPTH  = 3,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- sv/cbsfc_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on cbsfc_pkg for operand and product types.
`default_nettype none

module cbsfc_mul (
    input  wire logic              aclk,
    input  wire cbsfc_pkg::mul_op_t a,
    input  wire cbsfc_pkg::mul_op_t b,
    output cbsfc_pkg::prod_t        prod
);

    cbsfc_pkg::prod_t prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

// ----- sv/console_buss_saturate_filter_clip_top.sv -----
// Console buss output stage: gain, sine saturation, optional biquad lowpass and
// asymmetric soft clip. Uses cbsfc_pkg, cbsfc_mul, cbsfc_ram and assert_macros.svh.
//
// Usage:
//   Input channel s_valid/s_ready carries one Q8.24 sample and its Q2.24 gain
//   per transaction; result channel m_valid/m_ready carries one Q8.24 sample.
//   The configuration channel cfg_valid/cfg_ready writes one register per
//   transaction (0 filter enable, 1 a0, 2 b1, 3 b2, 4 delay spacing) and is
//   always ready. Write it only while the block is idle.
//   Each transaction returns the clipped sample of the previous transaction
//   (the first returns zero). The delay spacing does not change the output.
//   Each item runs 18 to 23 products in sequence on one shared 34x34
//   multiplier, plus the state memory write-back. The block is ready for the
//   next item in the cycle after the result is loaded, and takes no new item
//   while one is in progress.
//   Filter states and the held clip sample live in a three-entry RAM that is
//   read at the start and written back at the end of each item.
//   Reset clears the configuration, the clip flags and the RAM valid bits, so
//   the stored state reads as zero. When the receiver stalls, the result
//   register holds and the block waits with the next result finished.
`default_nettype none
`include "assert_macros.svh"

module console_buss_saturate_filter_clip_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_sample_in,
    input  wire logic [25:0] s_gain,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_sample_out,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_XG    = 5'd1;
    localparam logic [4:0] ST_SQ_I  = 5'd2;
    localparam logic [4:0] ST_SQ_T  = 5'd3;
    localparam logic [4:0] ST_ZT_I  = 5'd4;
    localparam logic [4:0] ST_ZT_T  = 5'd5;
    localparam logic [4:0] ST_DV_I  = 5'd6;
    localparam logic [4:0] ST_DV_T  = 5'd7;
    localparam logic [4:0] ST_XT_I  = 5'd8;
    localparam logic [4:0] ST_XT_T  = 5'd9;
    localparam logic [4:0] ST_FA_I  = 5'd10;
    localparam logic [4:0] ST_FA_T  = 5'd11;
    localparam logic [4:0] ST_FB1_I = 5'd12;
    localparam logic [4:0] ST_FB1_T = 5'd13;
    localparam logic [4:0] ST_FB2_I = 5'd14;
    localparam logic [4:0] ST_FB2_T = 5'd15;
    localparam logic [4:0] ST_G2_I  = 5'd16;
    localparam logic [4:0] ST_G2_T  = 5'd17;
    localparam logic [4:0] ST_P_I   = 5'd18;
    localparam logic [4:0] ST_P_T   = 5'd19;
    localparam logic [4:0] ST_PR_I  = 5'd20;
    localparam logic [4:0] ST_PR_T  = 5'd21;
    localparam logic [4:0] ST_N_I   = 5'd22;
    localparam logic [4:0] ST_N_T   = 5'd23;
    localparam logic [4:0] ST_NR_I  = 5'd24;
    localparam logic [4:0] ST_NR_T  = 5'd25;
    localparam logic [4:0] ST_WB0   = 5'd26;
    localparam logic [4:0] ST_WB1   = 5'd27;
    localparam logic [4:0] ST_WB2   = 5'd28;
    localparam logic [4:0] ST_OUT   = 5'd29;

    logic [4:0] state_reg, state_next;
    logic [1:0] rd_phase_reg, rd_phase_next;
    logic       m_valid_reg, m_valid_next;
    logic [2:0] ram_valid_reg, ram_valid_next;
    logic       rd_valid_reg;
    logic       pflag_reg, pflag_next;
    logic       nflag_reg, nflag_next;

    logic                filter_enable_reg;
    cbsfc_pkg::sample_t  coef_a0_reg, coef_b1_reg, coef_b2_reg;

    cbsfc_pkg::sample_t        x_reg, x_next;
    logic [25:0]               g_reg, g_next;
    logic [31:0]               z_reg, z_next;
    logic [31:0]               q_reg, q_next;
    cbsfc_pkg::sample_t        t_reg, t_next;
    logic [2:0]                k_reg, k_next;
    cbsfc_pkg::sample_t        y_reg, y_next;
    logic signed [34:0]        m0_reg, m0_next;
    logic signed [35:0]        m1_reg, m1_next;
    cbsfc_pkg::fstate_t        s1_reg, s1_next;
    cbsfc_pkg::fstate_t        s2_reg, s2_next;
    cbsfc_pkg::sample_t        held_reg, held_next;
    cbsfc_pkg::sample_t        out_reg, out_next;

    cbsfc_pkg::mul_op_t mul_a, mul_b;
    cbsfc_pkg::prod_t   prod;
    cbsfc_pkg::prod_t   r24, r27, r28, r30, r_sine;
    logic [29:0]        quot;

    logic                         ram_we;
    cbsfc_pkg::ram_addr_t         ram_waddr, ram_raddr;
    logic [cbsfc_pkg::STATE_W-1:0] ram_wdata, ram_rdata, rd_data;

    cbsfc_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    cbsfc_ram #(
        .WIDTH (cbsfc_pkg::STATE_W),
        .DEPTH (cbsfc_pkg::RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_sample_out = out_reg;
    assign cfg_ready    = 1'b1;

    assign r24    = cbsfc_pkg::rnd_shift(prod, 24);
    assign r27    = cbsfc_pkg::rnd_shift(prod, 27);
    assign r28    = cbsfc_pkg::rnd_shift(prod, 28);
    assign r30    = cbsfc_pkg::rnd_shift(prod, 30);
    assign r_sine = cbsfc_pkg::rnd_shift(r30, 6);
    assign quot   = cbsfc_pkg::div_quot(prod, k_reg);
    assign rd_data = rd_valid_reg ? ram_rdata : '0;

    always_comb begin
        case (rd_phase_reg)
            2'd1:    ram_raddr = cbsfc_pkg::ADDR_S2;
            2'd2:    ram_raddr = cbsfc_pkg::ADDR_HELD;
            default: ram_raddr = cbsfc_pkg::ADDR_S1;
        endcase
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_IDLE: begin
                mul_a = cbsfc_pkg::mul_op_t'($signed(s_sample_in));
                mul_b = $signed({8'b0, s_gain});
            end
            ST_SQ_I: begin
                mul_a = cbsfc_pkg::mul_op_t'(x_reg);
                mul_b = cbsfc_pkg::mul_op_t'(x_reg);
            end
            ST_ZT_I: begin
                mul_a = $signed({2'b00, z_reg});
                mul_b = cbsfc_pkg::mul_op_t'(t_reg);
            end
            ST_DV_I: begin
                mul_a = $signed({2'b00, q_reg});
                mul_b = $signed({1'b0, cbsfc_pkg::div_mul(k_reg)});
            end
            ST_XT_I: begin
                mul_a = cbsfc_pkg::mul_op_t'(x_reg);
                mul_b = cbsfc_pkg::mul_op_t'(t_reg);
            end
            ST_FA_I: begin
                mul_a = cbsfc_pkg::mul_op_t'(x_reg);
                mul_b = cbsfc_pkg::mul_op_t'(coef_a0_reg);
            end
            ST_FB1_I: begin
                mul_a = cbsfc_pkg::mul_op_t'(y_reg);
                mul_b = cbsfc_pkg::mul_op_t'(coef_b1_reg);
            end
            ST_FB2_I: begin
                mul_a = cbsfc_pkg::mul_op_t'(y_reg);
                mul_b = cbsfc_pkg::mul_op_t'(coef_b2_reg);
            end
            ST_G2_I: begin
                mul_a = cbsfc_pkg::mul_op_t'(x_reg);
                mul_b = $signed({8'b0, g_reg});
            end
            ST_P_I: begin
                if (x_reg < held_reg) begin
                    mul_a = cbsfc_pkg::mul_op_t'(x_reg);
                    mul_b = cbsfc_pkg::mul_op_t'(cbsfc_pkg::CLIP_MUL);
                end else begin
                    mul_a = cbsfc_pkg::mul_op_t'(held_reg);
                    mul_b = cbsfc_pkg::mul_op_t'(cbsfc_pkg::REL_MUL);
                end
            end
            ST_N_I: begin
                if (x_reg > held_reg) begin
                    mul_a = cbsfc_pkg::mul_op_t'(x_reg);
                    mul_b = cbsfc_pkg::mul_op_t'(cbsfc_pkg::CLIP_MUL);
                end else begin
                    mul_a = cbsfc_pkg::mul_op_t'(held_reg);
                    mul_b = cbsfc_pkg::mul_op_t'(cbsfc_pkg::REL_MUL);
                end
            end
            ST_PR_I, ST_NR_I: begin
                mul_a = cbsfc_pkg::mul_op_t'(held_reg);
                mul_b = cbsfc_pkg::mul_op_t'(cbsfc_pkg::CLIP_MUL);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        rd_phase_next  = rd_phase_reg;
        m_valid_next   = m_valid_reg;
        ram_valid_next = ram_valid_reg;
        pflag_next     = pflag_reg;
        nflag_next     = nflag_reg;
        x_next         = x_reg;
        g_next         = g_reg;
        z_next         = z_reg;
        q_next         = q_reg;
        t_next         = t_reg;
        k_next         = k_reg;
        y_next         = y_reg;
        m0_next        = m0_reg;
        m1_next        = m1_reg;
        s1_next        = s1_reg;
        s2_next        = s2_reg;
        held_next      = held_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = cbsfc_pkg::ADDR_S1;
        ram_wdata      = s1_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (rd_phase_reg)
            2'd1: begin
                s1_next       = rd_data;
                rd_phase_next = 2'd2;
            end
            2'd2: begin
                s2_next       = rd_data;
                rd_phase_next = 2'd3;
            end
            2'd3: begin
                held_next     = rd_data[cbsfc_pkg::SAMPLE_W-1:0];
                rd_phase_next = 2'd0;
            end
            default: begin
                rd_phase_next = rd_phase_reg;
            end
        endcase

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    g_next        = s_gain;
                    rd_phase_next = 2'd1;
                    state_next    = ST_XG;
                end
            end
            ST_XG: begin
                x_next     = cbsfc_pkg::clamp_sym(r24, cbsfc_pkg::HALF_PI_Q24) <<< 6;
                state_next = ST_SQ_I;
            end
            ST_SQ_I:  state_next = ST_SQ_T;
            ST_SQ_T: begin
                z_next     = r30[31:0];
                t_next     = cbsfc_pkg::ONE_Q30;
                k_next     = '0;
                state_next = ST_ZT_I;
            end
            ST_ZT_I:  state_next = ST_ZT_T;
            ST_ZT_T: begin
                q_next     = r30[31:0];
                state_next = ST_DV_I;
            end
            ST_DV_I:  state_next = ST_DV_T;
            ST_DV_T: begin
                t_next = cbsfc_pkg::ONE_Q30 - $signed({2'b00, quot});
                if (k_reg == 3'(cbsfc_pkg::DIV_STEPS - 1)) begin
                    state_next = ST_XT_I;
                end else begin
                    k_next     = k_reg + 3'd1;
                    state_next = ST_ZT_I;
                end
            end
            ST_XT_I:  state_next = ST_XT_T;
            ST_XT_T: begin
                x_next     = r_sine[31:0];
                state_next = filter_enable_reg ? ST_FA_I : ST_G2_I;
            end
            ST_FA_I:  state_next = ST_FA_T;
            ST_FA_T: begin
                m0_next    = r28[34:0];
                m1_next    = r27[35:0];
                y_next     = cbsfc_pkg::sat32(r28 + cbsfc_pkg::prod_t'(s1_reg));
                state_next = ST_FB1_I;
            end
            ST_FB1_I: state_next = ST_FB1_T;
            ST_FB1_T: begin
                s1_next    = cbsfc_pkg::sat40(cbsfc_pkg::prod_t'(m1_reg) - r28
                                              + cbsfc_pkg::prod_t'(s2_reg));
                state_next = ST_FB2_I;
            end
            ST_FB2_I: state_next = ST_FB2_T;
            ST_FB2_T: begin
                s2_next    = cbsfc_pkg::sat40(cbsfc_pkg::prod_t'(m0_reg) - r28);
                x_next     = y_reg;
                state_next = ST_G2_I;
            end
            ST_G2_I:  state_next = ST_G2_T;
            ST_G2_T: begin
                x_next     = cbsfc_pkg::clamp_sym(r24, cbsfc_pkg::FOUR_Q24);
                state_next = ST_P_I;
            end
            ST_P_I:   state_next = ST_P_T;
            ST_P_T: begin
                if (pflag_reg) begin
                    if (x_reg < held_reg) begin
                        held_next = cbsfc_pkg::CLIP_BASE + r24[31:0];
                    end else begin
                        held_next = cbsfc_pkg::REL_BASE + r24[31:0];
                    end
                end
                pflag_next = (x_reg > cbsfc_pkg::CLIP_THRESH);
                state_next = (x_reg > cbsfc_pkg::CLIP_THRESH) ? ST_PR_I : ST_N_I;
            end
            ST_PR_I:  state_next = ST_PR_T;
            ST_PR_T: begin
                x_next     = cbsfc_pkg::CLIP_BASE + r24[31:0];
                state_next = ST_N_I;
            end
            ST_N_I:   state_next = ST_N_T;
            ST_N_T: begin
                if (nflag_reg) begin
                    if (x_reg > held_reg) begin
                        held_next = cbsfc_pkg::NEG_BASE + r24[31:0];
                    end else begin
                        held_next = cbsfc_pkg::NEG_REL + r24[31:0];
                    end
                end
                nflag_next = (x_reg < cbsfc_pkg::NEG_THRESH);
                state_next = (x_reg < cbsfc_pkg::NEG_THRESH) ? ST_NR_I : ST_WB0;
            end
            ST_NR_I:  state_next = ST_NR_T;
            ST_NR_T: begin
                x_next     = cbsfc_pkg::NEG_BASE + r24[31:0];
                state_next = ST_WB0;
            end
            ST_WB0: begin
                ram_we                              = 1'b1;
                ram_waddr                           = cbsfc_pkg::ADDR_S1;
                ram_wdata                           = s1_reg;
                ram_valid_next[cbsfc_pkg::ADDR_S1]  = 1'b1;
                state_next                          = ST_WB1;
            end
            ST_WB1: begin
                ram_we                              = 1'b1;
                ram_waddr                           = cbsfc_pkg::ADDR_S2;
                ram_wdata                           = s2_reg;
                ram_valid_next[cbsfc_pkg::ADDR_S2]  = 1'b1;
                state_next                          = ST_WB2;
            end
            ST_WB2: begin
                ram_we                                = 1'b1;
                ram_waddr                             = cbsfc_pkg::ADDR_HELD;
                ram_wdata                             = cbsfc_pkg::fstate_t'(x_reg);
                ram_valid_next[cbsfc_pkg::ADDR_HELD]  = 1'b1;
                state_next                            = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = held_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            rd_phase_reg      <= 2'd0;
            m_valid_reg       <= 1'b0;
            ram_valid_reg     <= '0;
            rd_valid_reg      <= 1'b0;
            pflag_reg         <= 1'b0;
            nflag_reg         <= 1'b0;
            filter_enable_reg <= 1'b0;
            coef_a0_reg       <= '0;
            coef_b1_reg       <= '0;
            coef_b2_reg       <= '0;
        end else begin
            state_reg     <= state_next;
            rd_phase_reg  <= rd_phase_next;
            m_valid_reg   <= m_valid_next;
            ram_valid_reg <= ram_valid_next;
            rd_valid_reg  <= ram_valid_reg[ram_raddr];
            pflag_reg     <= pflag_next;
            nflag_reg     <= nflag_next;
            if (cfg_valid) begin
                case (cfg_index)
                    cbsfc_pkg::CFG_FILTER_ENABLE: filter_enable_reg <= cfg_data[0];
                    cbsfc_pkg::CFG_COEF_A0:       coef_a0_reg       <= cfg_data;
                    cbsfc_pkg::CFG_COEF_B1:       coef_b1_reg       <= cfg_data;
                    cbsfc_pkg::CFG_COEF_B2:       coef_b2_reg       <= cfg_data;
                    cbsfc_pkg::CFG_DELAY_SPACING: ;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_reg    <= x_next;
        g_reg    <= g_next;
        z_reg    <= z_next;
        q_reg    <= q_next;
        t_reg    <= t_next;
        k_reg    <= k_next;
        y_reg    <= y_next;
        m0_reg   <= m0_next;
        m1_reg   <= m1_next;
        s1_reg   <= s1_next;
        s2_reg   <= s2_next;
        held_reg <= held_next;
        out_reg  <= out_next;
    end

    `ASSERT_IMPL(a_loop_bound, (state_reg == ST_DV_T), (k_reg < 3'(cbsfc_pkg::DIV_STEPS)), "series index out of range")
    `ASSERT_IMPL(a_no_write_idle, (state_reg == ST_IDLE), (!ram_we), "state memory written while idle")
    `ASSERT_NEXT(a_accept_starts, (s_valid && s_ready), (state_reg == ST_XG && rd_phase_reg == 2'd1), "accepted transaction did not start")
    `ASSERT_IMPL(a_series_positive, (state_reg == ST_ZT_I), (t_reg > 0), "sine series term not positive")

endmodule

`default_nettype wire
